### design/dcp_pkg.sv
// Shared types and constants for the duty-cycle command parser.
`default_nettype none
package dcp_pkg;

    // Parser state codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_MOTOR = 2'd2;
    localparam logic [1:0] ST_VALUE = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_INCOMPLETE = 2'd0;
    localparam logic [1:0] STAT_COMPLETE   = 2'd1;
    localparam logic [1:0] STAT_NOMATCH    = 2'd2;

    // Characters of the command syntax
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // Value limits
    localparam logic [11:0] VALUE_MAX    = 12'd200;
    localparam logic [7:0]  VALUE_CENTER = 8'd100;
    localparam logic [3:0]  DIGITS_MAX   = 4'd8;
    localparam logic [3:0]  MOTOR_MAX    = 4'd9;
    localparam logic [6:0]  MAG_MAX      = 7'd100;

    // One result transaction
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] motor_id;
        logic       direction;
        logic [6:0] duty_magnitude;
    } result_t;

endpackage
`default_nettype wire

### design/dcp_in_stage.sv
// Input holding register for received bytes.
`default_nettype none
module dcp_in_stage
    import dcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       down_ready,
    output logic            stage_valid,
    output logic [7:0]      stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // Accept when empty or when the held byte moves on this cycle
    assign in_ready   = !valid_reg || down_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = take ? 1'b1 : (down_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

endmodule
`default_nettype wire

### design/dcp_parser.sv
// Command recognizer: parse state, value accumulator and result decode.
`default_nettype none
module dcp_parser
    import dcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] c,
    output result_t         result
);

    logic [1:0]  state_reg, state_next;
    logic [3:0]  digits_left_reg, digits_left_next;
    logic [3:0]  motor_reg, motor_next;
    logic [7:0]  acc_reg, acc_next;
    logic        over_reg, over_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] prod;
    logic        over_new;
    logic [3:0]  dl_dec;
    logic        matched;
    logic        done;
    logic [7:0]  value;
    logic        fwd;

    assign is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
    assign digit    = c[3:0];
    assign dl_dec   = digits_left_reg - 4'd1;

    // acc * 10 + digit; values past 200 only need the sticky overflow flag
    assign prod     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {8'h00, digit};
    assign over_new = over_reg || (prod > VALUE_MAX);
    assign value    = prod[7:0];
    assign fwd      = value >= VALUE_CENTER;

    // Next state; a failing byte is retried from idle
    always_comb
    begin
        state_next       = state_reg;
        digits_left_next = digits_left_reg;
        motor_next       = motor_reg;
        acc_next         = acc_reg;
        over_next        = over_reg;
        matched          = 1'b0;
        done             = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (c == CHAR_PERCENT)
                begin
                    state_next = ST_LEN;
                    matched    = 1'b1;
                end
            end
            ST_LEN:
            begin
                if (c inside {[CHAR_ONE:CHAR_NINE]})
                begin
                    digits_left_next = digit;
                    state_next       = ST_MOTOR;
                    matched          = 1'b1;
                end
            end
            ST_MOTOR:
            begin
                if (is_digit)
                begin
                    motor_next       = digit;
                    acc_next         = 8'd0;
                    over_next        = 1'b0;
                    digits_left_next = dl_dec;
                    state_next       = ST_VALUE;
                    matched          = 1'b1;
                end
            end
            ST_VALUE:
            begin
                if (is_digit && (digits_left_reg != 4'd0))
                begin
                    acc_next         = value;
                    over_next        = over_new;
                    digits_left_next = dl_dec;
                    if (digits_left_reg == 4'd1)
                    begin
                        if (!over_new)
                        begin
                            done       = 1'b1;
                            matched    = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        matched = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Retry from idle: only a percent sign starts a new command
        if (!matched)
        begin
            state_next = (c == CHAR_PERCENT) ? ST_LEN : ST_IDLE;
        end
    end

    // Result decode
    always_comb
    begin
        result = '0;
        if (done)
        begin
            result.status         = STAT_COMPLETE;
            result.motor_id       = motor_reg;
            result.direction      = fwd;
            result.duty_magnitude = fwd ? 7'(value - VALUE_CENTER) : 7'(VALUE_CENTER - value);
        end
        else if (matched || (c == CHAR_PERCENT))
        begin
            result.status = STAT_INCOMPLETE;
        end
        else
        begin
            result.status = STAT_NOMATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            digits_left_reg <= 4'd0;
            motor_reg       <= 4'd0;
            acc_reg         <= 8'd0;
            over_reg        <= 1'b0;
        end
        else if (step)
        begin
            state_reg       <= state_next;
            digits_left_reg <= digits_left_next;
            motor_reg       <= motor_next;
            acc_reg         <= acc_next;
            over_reg        <= over_next;
        end
    end

`ifndef SYNTHESIS
    // A completed command carries a legal motor and magnitude
    a_complete_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.status == STAT_COMPLETE) |->
        ((result.duty_magnitude <= MAG_MAX) && (result.motor_id <= MOTOR_MAX)))
        else $error("complete result out of range");

    // At most eight value digits are ever pending
    a_digits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VALUE) |-> (digits_left_reg <= DIGITS_MAX))
        else $error("digit count out of range");

    // Completion returns the parser to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (result.status == STAT_COMPLETE)) |=> (state_reg == ST_IDLE))
        else $error("parser not idle after complete");
`endif

endmodule
`default_nettype wire

### design/dcp_out_stage.sv
// Result register with valid/ready toward the consumer.
`default_nettype none
module dcp_out_stage
    import dcp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  result_t    load_result,
    output logic       up_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held result is taken this cycle
    assign up_ready   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
`default_nettype wire

### design/duty_cycle_command_parser.sv
// Top level of the duty-cycle command parser.
// An accepted byte is held in the input register, parsed combinationally, and its result
// is loaded into the result register, which drives out_valid and the result outputs.
// Throughput: one byte per cycle; the input register, parser and result register
// form a two-stage pipeline that advances whenever the result register is free.
// Reset (rst_n, asynchronous, active low) empties both stages and returns the
// parser to waiting for a percent sign.
`default_nettype none
module duty_cycle_command_parser
    import dcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic [1:0]      status,
    output logic [3:0]      motor_id,
    output logic            direction,
    output logic [6:0]      duty_magnitude,
    output logic            out_valid,
    input  wire logic       out_ready
);

    logic       stage_valid;
    logic [7:0] stage_byte;
    logic       up_ready;
    logic       adv;
    result_t    parse_result;
    result_t    out_result;

    // Parser steps when a byte is held and the result register can take it
    assign adv = stage_valid && up_ready;

    dcp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .down_ready  (up_ready),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    dcp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (adv),
        .c      (stage_byte),
        .result (parse_result)
    );

    dcp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (adv),
        .load_result (parse_result),
        .up_ready    (up_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign status         = out_result.status;
    assign motor_id       = out_result.motor_id;
    assign direction      = out_result.direction;
    assign duty_magnitude = out_result.duty_magnitude;

endmodule
`default_nettype wire
